// ===== hw/rtl/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, codes and character tables for the script token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int TOKEN_LEN_DEF = 32;

  // Token type codes
  localparam logic [4:0] TYPE_NUMBER  = 5'd0;
  localparam logic [4:0] TYPE_IDENT   = 5'd1;
  localparam logic [4:0] TYPE_STRING  = 5'd2;
  localparam logic [4:0] TYPE_HASH    = 5'd3;
  localparam logic [4:0] TYPE_COLON   = 5'd4;
  localparam logic [4:0] TYPE_SEMI    = 5'd5;
  localparam logic [4:0] TYPE_EQUALS  = 5'd6;
  localparam logic [4:0] TYPE_LBRACE  = 5'd7;
  localparam logic [4:0] TYPE_RBRACE  = 5'd8;
  localparam logic [4:0] TYPE_LPAREN  = 5'd9;
  localparam logic [4:0] TYPE_RPAREN  = 5'd10;
  localparam logic [4:0] TYPE_LBRACK  = 5'd11;
  localparam logic [4:0] TYPE_RBRACK  = 5'd12;
  localparam logic [4:0] TYPE_COMMA   = 5'd13;
  localparam logic [4:0] TYPE_DEFINE  = 5'd14;
  localparam logic [4:0] TYPE_INCLUDE = 5'd15;
  localparam logic [4:0] TYPE_SETDIR  = 5'd16;
  localparam logic [4:0] TYPE_UNDEF   = 5'd17;
  localparam logic [4:0] TYPE_ERROR   = 5'd18;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_TRUNC   = 2'd2;
  localparam logic [1:0] ERR_UNTERM  = 2'd3;

  // Characters with a role of their own
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef enum logic [2:0] {
    M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_STAR, M_NUM, M_IDENT, M_STR
  } scan_mode_t;

  typedef enum logic [2:0] {
    CLS_SPACE, CLS_NUM, CLS_LETTER, CLS_SYMBOL, CLS_QUOTE
  } char_cls_t;

  // Keywords, lower case, zero padded
  localparam int KW_COUNT = 4;
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"d", "e", "f", "i", "n", "e", 8'h00, 8'h00},
    '{"i", "n", "c", "l", "u", "d", "e", 8'h00},
    '{"s", "e", "t", "d", "i", "r", 8'h00, 8'h00},
    '{"u", "n", "d", "e", "f", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [5:0] KW_LEN [KW_COUNT] = '{6'd6, 6'd7, 6'd6, 6'd5};

  function automatic char_cls_t classify(input logic [7:0] c);
    char_cls_t cls;
    if ((c >= "0" && c <= "9") || c == CH_MINUS || c == CH_DOT) cls = CLS_NUM;
    else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_UNDER)
      cls = CLS_LETTER;
    else if (c == CH_QUOTE) cls = CLS_QUOTE;
    else if (c >= "!" && c <= "~") cls = CLS_SYMBOL;
    else cls = CLS_SPACE;
    return cls;
  endfunction

  function automatic logic [4:0] sym_type(input logic [7:0] c);
    logic [4:0] t;
    unique case (c)
      "#":     t = TYPE_HASH;
      ":":     t = TYPE_COLON;
      ";":     t = TYPE_SEMI;
      "=":     t = TYPE_EQUALS;
      "{":     t = TYPE_LBRACE;
      "}":     t = TYPE_RBRACE;
      "(":     t = TYPE_LPAREN;
      ")":     t = TYPE_RPAREN;
      "[":     t = TYPE_LBRACK;
      "]":     t = TYPE_RBRACK;
      ",":     t = TYPE_COMMA;
      default: t = TYPE_ERROR;
    endcase
    return t;
  endfunction

  // Advance the per-keyword prefix match by one appended byte at pos
  function automatic logic [KW_COUNT-1:0] kw_step(input logic [KW_COUNT-1:0] hits,
                                                 input logic [5:0] pos,
                                                 input logic [7:0] c);
    logic [KW_COUNT-1:0] h;
    logic [7:0] lc;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    for (int k = 0; k < KW_COUNT; k++)
      h[k] = hits[k] && (pos < KW_LEN[k]) && (lc == KW_TEXT[k][pos[2:0]]);
    return h;
  endfunction

  function automatic logic [4:0] kw_type(input logic [KW_COUNT-1:0] hits,
                                         input logic [5:0] len,
                                         input logic too_long);
    logic [4:0] t;
    priority if (!too_long && hits[0] && len == KW_LEN[0]) t = TYPE_DEFINE;
    else if (!too_long && hits[1] && len == KW_LEN[1]) t = TYPE_INCLUDE;
    else if (!too_long && hits[2] && len == KW_LEN[2]) t = TYPE_SETDIR;
    else if (!too_long && hits[3] && len == KW_LEN[3]) t = TYPE_UNDEF;
    else t = TYPE_IDENT;
    return t;
  endfunction

endpackage

// ===== hw/rtl/stl_if.sv =====
// ----------------------------------------------------------------------------
// stl_if
// Valid/ready channels of the script token lexer: input bytes and token items.
// ----------------------------------------------------------------------------
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface stl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_type;
  logic [7:0]  text_byte;
  logic        has_byte;
  logic [4:0]  byte_index;
  logic        last_of_token;
  logic [15:0] line_number;
  logic [1:0]  error_code;

  modport source (output valid, output token_type, output text_byte, output has_byte,
                  output byte_index, output last_of_token, output line_number,
                  output error_code, input ready);
  modport sink   (input valid, input token_type, input text_byte, input has_byte,
                  input byte_index, input last_of_token, input line_number,
                  input error_code, output ready);
endinterface

// ===== hw/rtl/stl_ram.sv =====
// ----------------------------------------------------------------------------
// stl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/script_token_lexer.sv =====
// ----------------------------------------------------------------------------
// script_token_lexer
// Byte-stream tokenizer with comment stripping, keyword and symbol detection.
// ----------------------------------------------------------------------------
// A byte that only extends a token, sits in a comment or is whitespace needs
// no state beyond the wait state. A byte that ends a number or identifier
// starts a run that, per text byte of that token, reads the token text RAM
// and then loads the output register, and then rescans the ending byte. A
// closing quote starts the same run, or a single textless item for an empty
// string, with no rescan. Each symbol or error item passes the one-item state,
// and the end of a buffer the end and clear states, beside any flush. The text
// of the pending token lives in a TOKEN_LEN-byte RAM; scan state, length, line
// count and keyword prefix matches live in registers. Stalls on the output
// side hold the sequencer; no reset pass is needed.
module script_token_lexer
  import stl_pkg::*;
#(
  parameter int TOKEN_LEN = TOKEN_LEN_DEF
) (
  input logic      clk,
  input logic      rst,
  stl_in_if.sink   char_stream,
  stl_out_if.source token_stream
);

  localparam int AW = $clog2(TOKEN_LEN);
  localparam int LW = $clog2(TOKEN_LEN + 1);

  typedef enum logic [2:0] {
    S_WAIT, S_IDLEB, S_ONE, S_RUN_RD, S_RUN_EM, S_END, S_CLEAR
  } state_t;

  state_t           state, state_next, cont, cont_next;
  scan_mode_t       mode, mode_next;
  logic [7:0]       cur_byte, cur_byte_next;
  logic             cur_last, cur_last_next;
  logic [LW-1:0]    tok_len, tok_len_next;
  logic             too_long, too_long_next;
  logic [15:0]      line_count, line_count_next;
  logic [KW_COUNT-1:0] kw_hits, kw_hits_next;
  logic [LW-1:0]    run_idx, run_idx_next;
  logic [4:0]       run_type, run_type_next;
  logic [1:0]       run_err, run_err_next;
  logic [4:0]       one_type, one_type_next;
  logic [7:0]       one_byte, one_byte_next;
  logic [1:0]       one_err, one_err_next;

  logic             o_valid, o_valid_next;
  logic [4:0]       o_type, o_type_next;
  logic [7:0]       o_byte, o_byte_next;
  logic             o_has, o_has_next;
  logic [4:0]       o_idx, o_idx_next;
  logic             o_last, o_last_next;
  logic [15:0]      o_line, o_line_next;
  logic [1:0]       o_err, o_err_next;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_rdata;

  logic [7:0]       in_mapped, c_now;
  logic             last_now, slot_free, run_done;
  state_t           finish_state;
  char_cls_t        cls_now;
  logic             do_idle, start_tok, append, bump;
  logic [LW-1:0]    app_pos;
  logic [KW_COUNT-1:0] hits_base;

  stl_ram #(.WIDTH(8), .DEPTH(TOKEN_LEN)) u_text (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (c_now),
    .raddr (run_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign char_stream.ready        = (state == S_WAIT);
  assign token_stream.valid       = o_valid;
  assign token_stream.token_type  = o_type;
  assign token_stream.text_byte   = o_byte;
  assign token_stream.has_byte    = o_has;
  assign token_stream.byte_index  = o_idx;
  assign token_stream.last_of_token = o_last;
  assign token_stream.line_number = o_line;
  assign token_stream.error_code  = o_err;

  // DEL reads as NUL
  assign in_mapped    = (char_stream.in_byte == CH_DEL) ? CH_NUL : char_stream.in_byte;
  assign c_now        = (state == S_WAIT) ? in_mapped : cur_byte;
  assign last_now     = (state == S_WAIT) ? char_stream.last_byte : cur_last;
  assign cls_now      = classify(c_now);
  assign finish_state = last_now ? S_END : S_WAIT;
  assign slot_free    = !o_valid || token_stream.ready;
  assign run_done     = (tok_len == '0) || ((run_idx + LW'(1)) == tok_len);

  always_comb begin
    state_next      = state;
    cont_next       = cont;
    mode_next       = mode;
    cur_byte_next   = cur_byte;
    cur_last_next   = cur_last;
    tok_len_next    = tok_len;
    too_long_next   = too_long;
    line_count_next = line_count;
    kw_hits_next    = kw_hits;
    run_idx_next    = run_idx;
    run_type_next   = run_type;
    run_err_next    = run_err;
    one_type_next   = one_type;
    one_byte_next   = one_byte;
    one_err_next    = one_err;
    o_valid_next    = o_valid && !token_stream.ready;
    o_type_next     = o_type;
    o_byte_next     = o_byte;
    o_has_next      = o_has;
    o_idx_next      = o_idx;
    o_last_next     = o_last;
    o_line_next     = o_line;
    o_err_next      = o_err;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    app_pos         = '0;
    hits_base       = '0;
    do_idle         = 1'b0;
    start_tok       = 1'b0;
    append          = 1'b0;
    bump            = 1'b0;

    unique case (state)
      S_WAIT: begin
        if (char_stream.valid) begin
          cur_byte_next = in_mapped;
          cur_last_next = char_stream.last_byte;
          state_next    = finish_state;
          unique case (mode)
            M_SLASH: begin
              if (c_now == CH_SLASH) mode_next = M_LINE;
              else if (c_now == CH_STAR) mode_next = M_BLOCK;
              else begin
                // lone slash: flag it, then treat this byte as fresh
                one_type_next = TYPE_ERROR;
                one_byte_next = CH_SLASH;
                one_err_next  = ERR_UNKNOWN;
                cont_next     = S_IDLEB;
                state_next    = S_ONE;
              end
            end
            M_LINE: begin
              if (c_now == CH_NL) begin
                bump      = 1'b1;
                mode_next = M_IDLE;
              end
            end
            M_BLOCK, M_STAR: begin
              if (mode == M_STAR && c_now == CH_SLASH) mode_next = M_IDLE;
              else if (c_now == CH_STAR) mode_next = M_STAR;
              else begin
                mode_next = M_BLOCK;
                bump      = (c_now == CH_NL);
              end
            end
            M_NUM, M_IDENT: begin
              if (cls_now == CLS_NUM || (mode == M_IDENT && cls_now == CLS_LETTER)) begin
                append = 1'b1;
              end else begin
                run_idx_next  = '0;
                run_type_next = (mode == M_NUM) ? TYPE_NUMBER
                                                : kw_type(kw_hits, 6'(tok_len), too_long);
                run_err_next  = too_long ? ERR_TRUNC : ERR_NONE;
                cont_next     = S_IDLEB;
                state_next    = S_RUN_RD;
              end
            end
            M_STR: begin
              if (c_now == CH_QUOTE) begin
                run_idx_next  = '0;
                run_type_next = TYPE_STRING;
                run_err_next  = too_long ? ERR_TRUNC : ERR_NONE;
                cont_next     = finish_state;
                mode_next     = M_IDLE;
                state_next    = S_RUN_RD;
              end else begin
                append = 1'b1;
              end
            end
            default: do_idle = 1'b1;
          endcase
        end
      end
      S_IDLEB: begin
        do_idle    = 1'b1;
        state_next = finish_state;
      end
      S_ONE: begin
        if (slot_free) begin
          o_valid_next = 1'b1;
          o_type_next  = one_type;
          o_byte_next  = one_byte;
          o_has_next   = 1'b1;
          o_idx_next   = '0;
          o_last_next  = 1'b1;
          o_line_next  = line_count;
          o_err_next   = one_err;
          state_next   = cont;
        end
      end
      S_RUN_RD: state_next = S_RUN_EM;
      S_RUN_EM: begin
        if (slot_free) begin
          o_valid_next = 1'b1;
          o_type_next  = run_type;
          o_byte_next  = (tok_len == '0) ? CH_NUL : ram_rdata;
          o_has_next   = (tok_len != '0);
          o_idx_next   = 5'(run_idx);
          o_last_next  = run_done;
          o_line_next  = line_count;
          o_err_next   = run_err;
          if (run_done) begin
            state_next = cont;
          end else begin
            run_idx_next = run_idx + LW'(1);
            state_next   = S_RUN_RD;
          end
        end
      end
      S_END: begin
        // end of buffer: flush what is pending, then clear
        cont_next     = S_CLEAR;
        run_idx_next  = '0;
        run_err_next  = too_long ? ERR_TRUNC : ERR_NONE;
        one_type_next = TYPE_ERROR;
        one_byte_next = CH_SLASH;
        one_err_next  = ERR_UNKNOWN;
        unique case (mode)
          M_NUM: begin
            run_type_next = TYPE_NUMBER;
            state_next    = S_RUN_RD;
          end
          M_IDENT: begin
            run_type_next = kw_type(kw_hits, 6'(tok_len), too_long);
            state_next    = S_RUN_RD;
          end
          M_STR: begin
            run_type_next = TYPE_STRING;
            run_err_next  = ERR_UNTERM;
            state_next    = S_RUN_RD;
          end
          M_SLASH: state_next = S_ONE;
          default: state_next = S_CLEAR;
        endcase
      end
      S_CLEAR: begin
        mode_next       = M_IDLE;
        tok_len_next    = '0;
        too_long_next   = 1'b0;
        line_count_next = 16'd1;
        state_next      = S_WAIT;
      end
      default: state_next = S_WAIT;
    endcase

    if (do_idle) begin
      mode_next = M_IDLE;
      if (c_now == CH_SLASH) begin
        mode_next = M_SLASH;
      end else begin
        unique case (cls_now)
          CLS_NUM: begin
            start_tok = 1'b1;
            append    = 1'b1;
            mode_next = M_NUM;
          end
          CLS_LETTER: begin
            start_tok = 1'b1;
            append    = 1'b1;
            mode_next = M_IDENT;
          end
          CLS_QUOTE: begin
            tok_len_next  = '0;
            too_long_next = 1'b0;
            mode_next     = M_STR;
          end
          CLS_SYMBOL: begin
            one_type_next = sym_type(c_now);
            one_byte_next = c_now;
            one_err_next  = (sym_type(c_now) == TYPE_ERROR) ? ERR_UNKNOWN : ERR_NONE;
            cont_next     = finish_state;
            state_next    = S_ONE;
          end
          default: bump = (c_now == CH_NL);
        endcase
      end
    end

    if (append) begin
      app_pos   = start_tok ? '0 : tok_len;
      hits_base = start_tok ? '1 : kw_hits;
      ram_waddr = app_pos[AW-1:0];
      if (app_pos < LW'(TOKEN_LEN)) begin
        ram_we        = 1'b1;
        tok_len_next  = app_pos + LW'(1);
        kw_hits_next  = kw_step(hits_base, 6'(app_pos), c_now);
        too_long_next = start_tok ? 1'b0 : too_long;
      end else begin
        // drop the byte, remember the overflow
        too_long_next = 1'b1;
      end
    end

    if (bump && line_count != 16'hFFFF) begin
      line_count_next = line_count + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_WAIT;
      mode       <= M_IDLE;
      tok_len    <= '0;
      too_long   <= 1'b0;
      line_count <= 16'd1;
      o_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      tok_len    <= tok_len_next;
      too_long   <= too_long_next;
      line_count <= line_count_next;
      o_valid    <= o_valid_next;
    end
    cont     <= cont_next;
    cur_byte <= cur_byte_next;
    cur_last <= cur_last_next;
    kw_hits  <= kw_hits_next;
    run_idx  <= run_idx_next;
    run_type <= run_type_next;
    run_err  <= run_err_next;
    one_type <= one_type_next;
    one_byte <= one_byte_next;
    one_err  <= one_err_next;
    o_type   <= o_type_next;
    o_byte   <= o_byte_next;
    o_has    <= o_has_next;
    o_idx    <= o_idx_next;
    o_last   <= o_last_next;
    o_line   <= o_line_next;
    o_err    <= o_err_next;
  end

endmodule

// ===== hw/rtl/stl_checker.sv =====
// ----------------------------------------------------------------------------
// stl_checker
// Port-level checks on the script token lexer, bound to the top level.
// ----------------------------------------------------------------------------
module stl_checker
  import stl_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  token_type,
  input logic [7:0]  text_byte,
  input logic        has_byte,
  input logic [4:0]  byte_index,
  input logic        last_of_token,
  input logic [15:0] line_number,
  input logic [1:0]  error_code
);

  logic [46:0] out_payload;
  assign out_payload = {token_type, text_byte, has_byte, byte_index, last_of_token,
                        line_number, error_code};

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("token item changed while stalled");

  // no new byte is taken while a token run is still going out
  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_token |-> !in_ready)
    else $error("input taken in the middle of a token run");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("lexer not idle after reset");

  // only an empty string carries no text
  a_empty_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> last_of_token && byte_index == 5'd0 &&
                               token_type == TYPE_STRING)
    else $error("textless item that is not an empty string");

  // an unknown symbol is always a single error item
  a_unknown_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_UNKNOWN |-> token_type == TYPE_ERROR &&
                                               last_of_token && byte_index == 5'd0)
    else $error("unknown-symbol code on a non-error item");

endmodule

bind script_token_lexer stl_checker u_stl_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (char_stream.ready),
  .out_valid     (token_stream.valid),
  .out_ready     (token_stream.ready),
  .token_type    (token_stream.token_type),
  .text_byte     (token_stream.text_byte),
  .has_byte      (token_stream.has_byte),
  .byte_index    (token_stream.byte_index),
  .last_of_token (token_stream.last_of_token),
  .line_number   (token_stream.line_number),
  .error_code    (token_stream.error_code)
);

// ===== bench/script_token_lexer_tb.sv =====
// ----------------------------------------------------------------------------
// script_token_lexer_tb
// Feeds script bytes into the lexer through its valid/ready channels and
// checks every token item against a cycle-free scanner model kept here.
// A short directed table comes first, then random buffers built from
// numbers, words, keywords, strings, symbols, comments and noise. The last
// buffers run with no idling on either side.
// ----------------------------------------------------------------------------
module script_token_lexer_tb;
  import stl_pkg::*;

  typedef struct packed {
    logic [4:0]  ttype;
    logic [7:0]  text;
    logic        has_text;
    logic [4:0]  pos;
    logic        tail;
    logic [15:0] line;
    logic [1:0]  err;
  } token_item_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        fin;
    logic        typed;
    token_item_t want;
  } script_row_t;

  localparam token_item_t NO_WANT = '0;
  localparam int N_ROWS = 26;
  localparam script_row_t SCRIPT_ROWS [N_ROWS] = '{
    '{"#", 1'b0, 1'b1, '{TYPE_HASH, "#", 1'b1, 5'd0, 1'b1, 16'd1, ERR_NONE}},
    '{"@", 1'b0, 1'b1, '{TYPE_ERROR, "@", 1'b1, 5'd0, 1'b1, 16'd1, ERR_UNKNOWN}},
    '{8'hFF, 1'b0, 1'b0, NO_WANT},
    '{CH_DEL, 1'b0, 1'b0, NO_WANT},
    '{CH_QUOTE, 1'b0, 1'b0, NO_WANT},
    '{CH_QUOTE, 1'b0, 1'b1, '{TYPE_STRING, 8'h00, 1'b0, 5'd0, 1'b1, 16'd1, ERR_NONE}},
    '{CH_SLASH, 1'b0, 1'b0, NO_WANT},
    '{"x", 1'b0, 1'b1, '{TYPE_ERROR, CH_SLASH, 1'b1, 5'd0, 1'b1, 16'd1, ERR_UNKNOWN}},
    '{CH_NL, 1'b0, 1'b0, NO_WANT},
    '{CH_SLASH, 1'b0, 1'b0, NO_WANT},
    '{CH_SLASH, 1'b0, 1'b0, NO_WANT},
    '{"z", 1'b0, 1'b0, NO_WANT},
    '{CH_NL, 1'b0, 1'b0, NO_WANT},
    '{CH_SLASH, 1'b0, 1'b0, NO_WANT},
    '{CH_STAR, 1'b0, 1'b0, NO_WANT},
    '{CH_NL, 1'b0, 1'b0, NO_WANT},
    '{CH_STAR, 1'b0, 1'b0, NO_WANT},
    '{CH_SLASH, 1'b0, 1'b0, NO_WANT},
    '{"U", 1'b0, 1'b0, NO_WANT},
    '{"N", 1'b0, 1'b0, NO_WANT},
    '{"D", 1'b0, 1'b0, NO_WANT},
    '{"E", 1'b0, 1'b0, NO_WANT},
    '{"F", 1'b0, 1'b0, NO_WANT},
    '{";", 1'b0, 1'b0, NO_WANT},
    '{CH_QUOTE, 1'b0, 1'b0, NO_WANT},
    '{"q", 1'b1, 1'b1, '{TYPE_STRING, "q", 1'b1, 5'd0, 1'b1, 16'd4, ERR_UNTERM}}
  };

  logic clk;
  logic rst;

  stl_in_if  char_if ();
  stl_out_if tok_if ();

  script_token_lexer u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_stream  (char_if),
    .token_stream (tok_if)
  );

  // Scanner model state
  scan_mode_t  lex_mode;
  logic [7:0]  lex_text [TOKEN_LEN_DEF];
  int          lex_len;
  bit          lex_over;
  logic [15:0] lex_line;

  token_item_t token_items_due [$];
  int          mismatches;
  bit          feed_gaps;
  bit          drain_gaps;

  function automatic char_cls_t byte_class(input logic [7:0] c);
    if ((c >= "0" && c <= "9") || c == CH_MINUS || c == CH_DOT) return CLS_NUM;
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_UNDER) return CLS_LETTER;
    if (c == CH_QUOTE) return CLS_QUOTE;
    if (c >= "!" && c <= "~") return CLS_SYMBOL;
    return CLS_SPACE;
  endfunction

  function automatic void clear_lexer();
    lex_mode = M_IDLE;
    lex_len  = 0;
    lex_over = 1'b0;
    lex_line = 16'd1;
  endfunction

  function automatic void count_line();
    if (lex_line != 16'hFFFF) lex_line++;
  endfunction

  function automatic void queue_item(input logic [4:0] tt, input logic [7:0] ch,
                                     input logic has, input int idx, input logic tail,
                                     input logic [1:0] err);
    token_item_t it;
    it = '{tt, ch, has, idx[4:0], tail, lex_line, err};
    token_items_due.push_back(it);
  endfunction

  function automatic void queue_token(input logic [4:0] tt, input logic [1:0] err);
    logic [1:0] e;
    e = (lex_over && err == ERR_NONE) ? ERR_TRUNC : err;
    if (lex_len == 0) queue_item(tt, 8'h00, 1'b0, 0, 1'b1, e);
    else
      for (int k = 0; k < lex_len; k++)
        queue_item(tt, lex_text[k], 1'b1, k, k == lex_len - 1, e);
  endfunction

  // Hold the first TOKEN_LEN bytes, flag the rest as lost
  function automatic void add_text(input logic [7:0] c);
    if (lex_len < TOKEN_LEN_DEF) begin
      lex_text[lex_len] = c;
      lex_len++;
    end else begin
      lex_over = 1'b1;
    end
  endfunction

  function automatic bit spells(input string kw);
    logic [7:0] lc;
    if (lex_over || lex_len != kw.len()) return 1'b0;
    for (int k = 0; k < lex_len; k++) begin
      lc = (lex_text[k] >= "A" && lex_text[k] <= "Z") ? lex_text[k] + 8'd32 : lex_text[k];
      if (lc != kw[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [4:0] word_type();
    if (spells("define")) return TYPE_DEFINE;
    if (spells("include")) return TYPE_INCLUDE;
    if (spells("setdir")) return TYPE_SETDIR;
    if (spells("undef")) return TYPE_UNDEF;
    return TYPE_IDENT;
  endfunction

  function automatic void queue_symbol(input logic [7:0] c);
    logic [4:0] tt;
    case (c)
      "#":     tt = TYPE_HASH;
      ":":     tt = TYPE_COLON;
      ";":     tt = TYPE_SEMI;
      "=":     tt = TYPE_EQUALS;
      "{":     tt = TYPE_LBRACE;
      "}":     tt = TYPE_RBRACE;
      "(":     tt = TYPE_LPAREN;
      ")":     tt = TYPE_RPAREN;
      "[":     tt = TYPE_LBRACK;
      "]":     tt = TYPE_RBRACK;
      ",":     tt = TYPE_COMMA;
      default: tt = TYPE_ERROR;
    endcase
    queue_item(tt, c, 1'b1, 0, 1'b1, (tt == TYPE_ERROR) ? ERR_UNKNOWN : ERR_NONE);
  endfunction

  // Byte seen outside any token or comment
  function automatic void lex_from_rest(input logic [7:0] c);
    lex_mode = M_IDLE;
    if (c == CH_SLASH) begin
      lex_mode = M_SLASH;
    end else begin
      case (byte_class(c))
        CLS_NUM: begin
          lex_len  = 0;
          lex_over = 1'b0;
          add_text(c);
          lex_mode = M_NUM;
        end
        CLS_LETTER: begin
          lex_len  = 0;
          lex_over = 1'b0;
          add_text(c);
          lex_mode = M_IDENT;
        end
        CLS_QUOTE: begin
          lex_len  = 0;
          lex_over = 1'b0;
          lex_mode = M_STR;
        end
        CLS_SYMBOL: queue_symbol(c);
        default: if (c == CH_NL) count_line();
      endcase
    end
  endfunction

  function automatic void lex_comment(input logic [7:0] c);
    if (c == CH_STAR) begin
      lex_mode = M_STAR;
    end else begin
      lex_mode = M_BLOCK;
      if (c == CH_NL) count_line();
    end
  endfunction

  function automatic void lex_byte(input logic [7:0] raw, input logic fin);
    logic [7:0] c;
    char_cls_t  cls;
    c   = (raw == CH_DEL) ? CH_NUL : raw;
    cls = byte_class(c);
    case (lex_mode)
      M_SLASH: begin
        if (c == CH_SLASH) lex_mode = M_LINE;
        else if (c == CH_STAR) lex_mode = M_BLOCK;
        else begin
          queue_item(TYPE_ERROR, CH_SLASH, 1'b1, 0, 1'b1, ERR_UNKNOWN);
          lex_from_rest(c);
        end
      end
      M_LINE: begin
        if (c == CH_NL) begin
          count_line();
          lex_mode = M_IDLE;
        end
      end
      M_BLOCK: lex_comment(c);
      M_STAR: begin
        if (c == CH_SLASH) lex_mode = M_IDLE;
        else lex_comment(c);
      end
      M_NUM: begin
        if (cls == CLS_NUM) add_text(c);
        else begin
          queue_token(TYPE_NUMBER, ERR_NONE);
          lex_from_rest(c);
        end
      end
      M_IDENT: begin
        if (cls == CLS_NUM || cls == CLS_LETTER) add_text(c);
        else begin
          queue_token(word_type(), ERR_NONE);
          lex_from_rest(c);
        end
      end
      M_STR: begin
        if (c == CH_QUOTE) begin
          queue_token(TYPE_STRING, ERR_NONE);
          lex_mode = M_IDLE;
        end else begin
          add_text(c);
        end
      end
      default: lex_from_rest(c);
    endcase
    // End of buffer: flush whatever is pending, drop open comments
    if (fin) begin
      case (lex_mode)
        M_NUM:   queue_token(TYPE_NUMBER, ERR_NONE);
        M_IDENT: queue_token(word_type(), ERR_NONE);
        M_STR:   queue_token(TYPE_STRING, ERR_UNTERM);
        M_SLASH: queue_item(TYPE_ERROR, CH_SLASH, 1'b1, 0, 1'b1, ERR_UNKNOWN);
        default: ;
      endcase
      clear_lexer();
    end
  endfunction

  // Offer one byte, wait for it to be taken, then predict its token items
  task automatic feed(input logic [7:0] ch, input logic fin, input logic typed,
                      input token_item_t want);
    int due;
    if (feed_gaps && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      char_if.valid <= 1'b0;
      repeat ($urandom_range(0, 18)) @(negedge clk);
    end
    @(negedge clk);
    char_if.valid     <= 1'b1;
    char_if.in_byte   <= ch;
    char_if.last_byte <= fin;
    @(posedge clk);
    while (!char_if.ready) @(posedge clk);
    due = token_items_due.size();
    lex_byte(ch, fin);
    if (typed) begin
      while (token_items_due.size() > due) void'(token_items_due.pop_back());
      token_items_due.push_back(want);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    tok_if.ready = 1'b0;
    forever begin
      if (drain_gaps && $urandom_range(0, 3) == 0) begin
        @(negedge clk);
        tok_if.ready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end
      @(negedge clk);
      tok_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    token_item_t got;
    token_item_t want;
    if (!rst && tok_if.valid && tok_if.ready) begin
      got = '{tok_if.token_type, tok_if.text_byte, tok_if.has_byte, tok_if.byte_index,
              tok_if.last_of_token, tok_if.line_number, tok_if.error_code};
      if (token_items_due.size() == 0) begin
        $display("%0t: unexpected token item: type %0d byte %h has %b idx %0d",
                 $time, got.ttype, got.text, got.has_text, got.pos,
                 " last %b line %0d err %0d", got.tail, got.line, got.err);
        mismatches++;
      end else begin
        want = token_items_due.pop_front();
        if (got !== want) begin
          $display("%0t: token item mismatch: expected type %0d byte %h has %b idx %0d",
                   $time, want.ttype, want.text, want.has_text, want.pos,
                   " last %b line %0d err %0d", want.tail, want.line, want.err);
          $display("%0t:                      actual   type %0d byte %h has %b idx %0d",
                   $time, got.ttype, got.text, got.has_text, got.pos,
                   " last %b line %0d err %0d", got.tail, got.line, got.err);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("script_token_lexer verification failed");
    $finish;
  end

  initial begin
    string      keywords [4];
    string      num_chars;
    string      ident_chars;
    string      sym_chars;
    string      comment_chars;
    string      lone_next;
    string      seps;
    string      word;
    logic [7:0] script [$];
    logic [7:0] ch;
    int         fed;
    int         pick;
    int         len;
    int         cut;

    keywords      = '{"define", "include", "setdir", "undef"};
    num_chars     = "0123456789-.";
    ident_chars   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789-.";
    sym_chars     = "#:;={}()[],";
    comment_chars = "*\n/x ";
    lone_next     = "a7#\" \n@";
    seps          = " \n;,=(";

    rst               = 1'b1;
    char_if.valid     = 1'b0;
    char_if.in_byte   = 8'h00;
    char_if.last_byte = 1'b0;
    feed_gaps         = 1'b1;
    drain_gaps        = 1'b1;
    mismatches        = 0;
    fed               = N_ROWS;
    clear_lexer();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++)
      feed(SCRIPT_ROWS[i].ch, SCRIPT_ROWS[i].fin, SCRIPT_ROWS[i].typed, SCRIPT_ROWS[i].want);

    // Random buffers: mostly well-formed tokens, some noise, cut short now and then;
    // the last ones run with no idling
    while (fed < 420) begin
      feed_gaps  = (fed < 340) && ($urandom_range(0, 3) != 0);
      drain_gaps = (fed < 340) && ($urandom_range(0, 3) != 0);
      script.delete();
      repeat ($urandom_range(1, 10)) begin
        pick = $urandom_range(0, 15);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
        case (pick)
          0, 1, 2: begin
            repeat (len) script.push_back(num_chars[$urandom_range(0, 11)]);
          end
          3, 4, 5: begin
            if ($urandom_range(0, 2) == 0) begin
              word = keywords[$urandom_range(0, 3)];
              // near miss: one byte short of the keyword
              if ($urandom_range(0, 4) == 0) word = word.substr(0, word.len() - 2);
              for (int k = 0; k < word.len(); k++)
                script.push_back($urandom_range(0, 1) ? word[k] - 8'd32 : word[k]);
            end else begin
              script.push_back(ident_chars[$urandom_range(0, 52)]);
              repeat (len - 1) script.push_back(ident_chars[$urandom_range(0, 64)]);
            end
          end
          6, 7: begin
            script.push_back(CH_QUOTE);
            repeat (($urandom_range(0, 3) == 0) ? 0 : len) begin
              do ch = 8'($urandom_range(0, 255)); while (ch == CH_QUOTE);
              script.push_back(ch);
            end
            script.push_back(CH_QUOTE);
          end
          8, 9: begin
            if ($urandom_range(0, 1) == 1) begin
              script.push_back(sym_chars[$urandom_range(0, 10)]);
            end else begin
              do ch = 8'($urandom_range(33, 126));
              while (byte_class(ch) != CLS_SYMBOL || ch == CH_SLASH);
              script.push_back(ch);
            end
          end
          10: begin
            script.push_back(CH_SLASH);
            script.push_back(CH_SLASH);
            repeat ($urandom_range(0, 5)) begin
              do ch = 8'($urandom_range(0, 255)); while (ch == CH_NL);
              script.push_back(ch);
            end
            script.push_back(CH_NL);
          end
          11: begin
            script.push_back(CH_SLASH);
            script.push_back(CH_STAR);
            repeat ($urandom_range(0, 6)) script.push_back(comment_chars[$urandom_range(0, 4)]);
            script.push_back(CH_STAR);
            script.push_back(CH_SLASH);
          end
          12: begin
            script.push_back(CH_SLASH);
            script.push_back(lone_next[$urandom_range(0, 6)]);
          end
          13, 14: begin
            repeat ($urandom_range(1, 3)) begin
              case ($urandom_range(0, 5))
                0:       ch = " ";
                1:       ch = CH_NL;
                2:       ch = 8'h09;
                3:       ch = CH_NUL;
                4:       ch = CH_DEL;
                default: ch = 8'($urandom_range(128, 255));
              endcase
              script.push_back(ch);
            end
          end
          default: begin
            repeat ($urandom_range(1, 3)) script.push_back(8'($urandom_range(0, 255)));
          end
        endcase
        if (pick <= 5 && $urandom_range(0, 3) != 0)
          script.push_back(seps[$urandom_range(0, 5)]);
      end
      if ($urandom_range(0, 2) == 0) begin
        cut    = $urandom_range(0, script.size() - 1);
        script = script[0:cut];
      end
      for (int k = 0; k < script.size(); k++) begin
        fed++;
        feed(script[k], k == script.size() - 1, 1'b0, NO_WANT);
      end
    end

    @(negedge clk);
    char_if.valid <= 1'b0;

    while (token_items_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("script_token_lexer verification clean");
    end else begin
      $display("script_token_lexer verification failed");
    end
    $finish;
  end

endmodule

// ===== script_token_lexer.f =====
hw/rtl/stl_pkg.sv
hw/rtl/stl_if.sv
hw/rtl/stl_ram.sv
hw/rtl/script_token_lexer.sv
hw/rtl/stl_checker.sv
bench/script_token_lexer_tb.sv
